### rtl/aacep_pkg.sv
// ----------------------------------------------------------------------------
// aacep_pkg
// Shared types, codes and helpers for the escape-pair Huffman encoder.
// ----------------------------------------------------------------------------
package aacep_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INDEX_BIAS      = 2'd0;
  localparam logic [1:0] REG_START_BYTE      = 2'd1;
  localparam logic [1:0] REG_START_BIT_COUNT = 2'd2;

  localparam int COEF_W    = 14;
  localparam int ESC_W     = 21;  // longest escape word: 2*8+5 bits
  localparam int SEG_W     = 96;  // left-aligned segment of one pair (max 74 bits)
  localparam int WIN_W     = 128; // pending bits plus one segment
  localparam int CODE_W    = 32;
  localparam int CLEN_W    = 6;

  // escape word of one coefficient, left-aligned
  typedef struct packed {
    logic [ESC_W-1:0] bits;
    logic [4:0]       len;
  } esc_t;

  // bits one item adds to the stream, left-aligned
  typedef struct packed {
    logic             flush;
    logic [SEG_W-1:0] bits;
    logic [6:0]       len;
  } seg_t;

  // results caused by one item
  typedef struct packed {
    logic [2:0][31:0] words;
    logic [1:0]       cnt;
    logic             has;
    logic [5:0]       wbits;
    logic [6:0]       pbits;
  } grp_t;

  // clip a coefficient to [-16, 16]
  function automatic logic signed [5:0] clip16(input logic signed [COEF_W-1:0] v);
    logic signed [5:0] r;
    if (v > 14'sd16) begin
      r = 6'sd16;
    end else if (v < -14'sd16) begin
      r = -6'sd16;
    end else begin
      r = v[5:0];
    end
    return r;
  endfunction

endpackage

### rtl/aac_escape_pair_huffman_encoder_top.sv
// ----------------------------------------------------------------------------
// aac_escape_pair_huffman_encoder_top
// Codebook-11 style pair encoder with escapes, packing 32-bit stream words.
// ----------------------------------------------------------------------------
// Path: an encode or flush item that is accepted passes the table read and
//   escape lanes, the merge and the pack into the output register before its
//   first result shows on m_tvalid.
// Throughput: one item per cycle while the output register is free; an item with
//   k results holds it until all k are taken, so the output side sets the rate.
// Reset: rst clears all control state, the bit buffer and the registers
//   (index_bias 1024, start byte and count 0). The code table is not cleared.
module aac_escape_pair_huffman_encoder_top #(
  parameter int TABLE_ADDR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // [13:0] coef_first, [27:14] coef_second, [39:28] table_index,
  // [45:40] table_length, [77:46] table_code, [79:78] zero
  input  logic [79:0] s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] out_word, [37:32] word_bits, [44:38] pair_bits, [47:45] zero
  output logic [47:0] m_tdata,
  // [0] has_word
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int DEPTH   = 1 << TABLE_ADDR_BITS;
  localparam int ENTRY_W = aacep_pkg::CLEN_W + aacep_pkg::CODE_W;

  // configuration registers
  logic [11:0] index_bias;
  logic [7:0]  start_byte;
  logic [2:0]  start_used;
  logic [7:0]  start_byte_new;
  logic [2:0]  start_used_new;
  logic        cfg_wr;
  logic        cfg_restart;

  // unpacked input fields
  logic [1:0]                          op;
  logic signed [aacep_pkg::COEF_W-1:0] coef_first;
  logic signed [aacep_pkg::COEF_W-1:0] coef_second;
  logic [11:0]                         table_index;
  logic [5:0]                          table_length;
  logic [31:0]                         table_code;

  // handshake chain
  logic in_acc;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic out_done;

  // stage 0: address and table
  logic signed [5:0]           c1_clip;
  logic signed [5:0]           c2_clip;
  logic [15:0]                 addr_sum;
  logic [TABLE_ADDR_BITS-1:0]  rd_addr;
  logic [TABLE_ADDR_BITS-1:0]  wr_addr;
  logic [15:0]                 idx_ext;
  logic [ENTRY_W-1:0]          tbl_mem [DEPTH];
  logic [ENTRY_W-1:0]          rd_entry;

  // stage 1
  logic             s1_valid;
  logic             s1_flush;
  aacep_pkg::esc_t  esc_first;
  aacep_pkg::esc_t  esc_second;

  // stage 2
  logic             s2_valid;
  aacep_pkg::seg_t  seg;

  // output register
  aacep_pkg::grp_t  grp;
  logic             g_valid;
  logic [1:0]       g_idx;
  logic             g_last;
  logic [31:0]      g_word;

  assign op           = s_tuser;
  assign coef_first   = s_tdata[13:0];
  assign coef_second  = s_tdata[27:14];
  assign table_index  = s_tdata[39:28];
  assign table_length = s_tdata[45:40];
  assign table_code   = s_tdata[77:46];

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    start_byte_new = start_byte;
    start_used_new = start_used;
    cfg_restart    = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        aacep_pkg::REG_START_BYTE: begin
          start_byte_new = cfg_data[7:0];
          cfg_restart    = 1'b1;
        end
        aacep_pkg::REG_START_BIT_COUNT: begin
          start_used_new = cfg_data[2:0];
          cfg_restart    = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bias <= 12'd1024;
      start_byte <= '0;
      start_used <= '0;
    end else begin
      start_byte <= start_byte_new;
      start_used <= start_used_new;
      if (cfg_wr && (cfg_index == aacep_pkg::REG_INDEX_BIAS)) begin
        index_bias <= cfg_data;
      end
    end
  end

  // ---------------- ready chain ----------------
  // Each stage moves on when the one after it is empty or moving on.
  assign out_done = m_tvalid && m_tready && m_tlast;
  assign rdy3     = !g_valid || out_done;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign s_tready = rdy1;
  assign in_acc   = s_tvalid && s_tready;

  // ---------------- stage 0: table address, table access ----------------
  always_comb begin
    c1_clip  = aacep_pkg::clip16(coef_first);
    c2_clip  = aacep_pkg::clip16(coef_second);
    // first*64 + second + 16 + bias, wrapped to the table size
    addr_sum = {{4{c1_clip[5]}}, c1_clip, 6'b0}
             + {{10{c2_clip[5]}}, c2_clip}
             + 16'd16
             + {4'b0, index_bias};
    rd_addr  = addr_sum[TABLE_ADDR_BITS-1:0];
    idx_ext  = {4'b0, table_index};
    wr_addr  = idx_ext[TABLE_ADDR_BITS-1:0];
  end

  // Load writes the entry; a following encode reads the new entry.
  always_ff @(posedge clk) begin
    if (in_acc && (op == aacep_pkg::OP_LOAD)) begin
      tbl_mem[wr_addr] <= {table_length, table_code};
    end
    if (rdy1) begin
      rd_entry <= tbl_mem[rd_addr];
    end
  end

  // escape lanes, one per coefficient
  aacep_esc_lane u_lane_first (
    .clk  (clk),
    .en   (rdy1),
    .coef (coef_first),
    .esc  (esc_first)
  );

  aacep_esc_lane u_lane_second (
    .clk  (clk),
    .en   (rdy1),
    .coef (coef_second),
    .esc  (esc_second)
  );

  // Only encode and flush travel on; load is done and op 3 is dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_acc && ((op == aacep_pkg::OP_ENCODE) || (op == aacep_pkg::OP_FLUSH));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_flush <= (op == aacep_pkg::OP_FLUSH);
    end
  end

  // ---------------- stage 1: merge lanes into one segment ----------------
  aacep_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (rdy2),
    .in_valid  (s1_valid),
    .in_flush  (s1_flush),
    .code_len  (rd_entry[ENTRY_W-1:aacep_pkg::CODE_W]),
    .code_bits (rd_entry[aacep_pkg::CODE_W-1:0]),
    .esc_a     (esc_first),
    .esc_b     (esc_second),
    .out_valid (s2_valid),
    .seg       (seg)
  );

  // ---------------- stage 2: bit buffer ----------------
  aacep_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .en      (rdy3 && s2_valid),
    .seg     (seg),
    .restart (cfg_restart),
    .rs_byte (start_byte_new),
    .rs_used (start_used_new),
    .grp     (grp)
  );

  // -------- output register: one word per cycle while m_tready is high --------
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      g_idx   <= '0;
    end else if (rdy3) begin
      g_valid <= s2_valid;
      g_idx   <= '0;
    end else if (m_tvalid && m_tready) begin
      g_idx <= g_idx + 2'd1;
    end
  end

  always_comb begin
    g_last = (g_idx == (grp.cnt - 2'd1));
    case (g_idx)
      2'd0:    g_word = grp.words[0];
      2'd1:    g_word = grp.words[1];
      default: g_word = grp.words[2];
    endcase
  end

  assign m_tvalid = g_valid;
  assign m_tlast  = g_last;
  assign m_tuser  = grp.has;
  assign m_tdata  = {3'b0, grp.pbits, grp.wbits, (grp.has ? g_word : 32'd0)};

endmodule

### rtl/aacep_esc_lane.sv
// ----------------------------------------------------------------------------
// aacep_esc_lane
// One escape lane: magnitude, leading-one detect and escape word, registered.
// ----------------------------------------------------------------------------
module aacep_esc_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [aacep_pkg::COEF_W-1:0] coef,
  output aacep_pkg::esc_t                     esc
);

  logic [aacep_pkg::COEF_W-1:0]  mag_raw;
  logic [12:0]                   mag;
  logic [3:0]                    msb;
  logic [3:0]                    n;
  logic [12:0]                   mag_sh;
  logic [aacep_pkg::ESC_W-1:0]   ones;
  logic [aacep_pkg::ESC_W-1:0]   mant;
  aacep_pkg::esc_t               esc_next;

  always_comb begin
    mag_raw = coef[aacep_pkg::COEF_W-1] ? (~coef + 14'd1) : coef;
    // only -8192 exceeds 8191; saturate it
    mag = mag_raw[13] ? 13'h1FFF : mag_raw[12:0];
    msb = 4'd4;
    for (int b = 4; b <= 12; b++) begin
      if (mag[b]) begin
        msb = 4'(b);
      end
    end
    n      = msb - 4'd4;
    // move the leading one to bit 12, mantissa follows below it
    mag_sh = mag << (4'd12 - msb);
    ones   = ~({aacep_pkg::ESC_W{1'b1}} >> n);
    mant   = {mag_sh[11:0], 9'b0} >> (n + 4'd1);
    if (mag < 13'd16) begin
      esc_next.bits = '0;
      esc_next.len  = '0;
    end else begin
      esc_next.bits = ones | mant;
      esc_next.len  = {n, 1'b0} + 5'd5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esc <= esc_next;
    end
  end

endmodule

### rtl/aacep_merge.sv
// ----------------------------------------------------------------------------
// aacep_merge
// Merge the Huffman code and both escape lanes into one left-aligned segment.
// ----------------------------------------------------------------------------
module aacep_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              in_flush,
  input  logic [aacep_pkg::CLEN_W-1:0]      code_len,
  input  logic [aacep_pkg::CODE_W-1:0]      code_bits,
  input  aacep_pkg::esc_t                   esc_a,
  input  aacep_pkg::esc_t                   esc_b,
  output logic                              out_valid,
  output aacep_pkg::seg_t                   seg
);

  logic [5:0]                         len_sat;
  logic [aacep_pkg::CODE_W-1:0]       code_l;
  logic [2*aacep_pkg::ESC_W-1:0]      esc_pair;
  logic [aacep_pkg::SEG_W-1:0]        esc_seg;
  aacep_pkg::seg_t                    seg_next;

  always_comb begin
    len_sat  = (code_len > 6'd32) ? 6'd32 : code_len;
    // left shift drops code bits above the length
    code_l   = code_bits << (6'd32 - len_sat);
    esc_pair = {esc_a.bits, {aacep_pkg::ESC_W{1'b0}}}
             | ({esc_b.bits, {aacep_pkg::ESC_W{1'b0}}} >> esc_a.len);
    esc_seg  = {esc_pair, {(aacep_pkg::SEG_W - 2*aacep_pkg::ESC_W){1'b0}}} >> len_sat;
    seg_next.flush = in_flush;
    seg_next.bits  = {code_l, {(aacep_pkg::SEG_W - aacep_pkg::CODE_W){1'b0}}} | esc_seg;
    seg_next.len   = 7'(len_sat) + 7'(esc_a.len) + 7'(esc_b.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg <= seg_next;
    end
  end

endmodule

### rtl/aacep_pack.sv
// ----------------------------------------------------------------------------
// aacep_pack
// Bit buffer: append a segment, cut full words, flush and restart.
// ----------------------------------------------------------------------------
module aacep_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  aacep_pkg::seg_t   seg,
  input  logic              restart,
  input  logic [7:0]        rs_byte,
  input  logic [2:0]        rs_used,
  output aacep_pkg::grp_t   grp
);

  // pending bits, left-aligned; bits past pend are zero
  logic [31:0]                  bit_buf;
  logic [4:0]                   pend;
  logic [31:0]                  bit_buf_next;
  logic [4:0]                   pend_next;
  logic [31:0]                  rs_buf;
  logic [aacep_pkg::WIN_W-1:0]  win;
  logic [6:0]                   total;
  logic [1:0]                   nw;
  aacep_pkg::grp_t              grp_next;

  always_comb begin
    rs_buf = {rs_byte & ~(8'hFF >> rs_used), 24'b0};
    win    = {bit_buf, {(aacep_pkg::WIN_W - 32){1'b0}}}
           | ({seg.bits, 32'b0} >> pend);
    total  = 7'(pend) + seg.len;
    nw     = total[6:5];

    bit_buf_next = bit_buf;
    pend_next    = pend;
    grp_next     = '0;
    if (restart) begin
      bit_buf_next = rs_buf;
      pend_next    = 5'(rs_used);
    end else if (en) begin
      if (seg.flush) begin
        grp_next.has      = (pend != 5'd0);
        grp_next.words[0] = bit_buf;
        grp_next.wbits    = {1'b0, pend};
        grp_next.cnt      = 2'd1;
        bit_buf_next      = rs_buf;
        pend_next         = 5'(rs_used);
      end else begin
        grp_next.has      = (nw != 2'd0);
        grp_next.words[0] = win[127:96];
        grp_next.words[1] = win[95:64];
        grp_next.words[2] = win[63:32];
        grp_next.wbits    = (nw != 2'd0) ? 6'd32 : 6'd0;
        grp_next.cnt      = (nw != 2'd0) ? nw : 2'd1;
        grp_next.pbits    = seg.len;
        pend_next         = total[4:0];
        case (nw)
          2'd0:    bit_buf_next = win[127:96];
          2'd1:    bit_buf_next = win[95:64];
          2'd2:    bit_buf_next = win[63:32];
          default: bit_buf_next = win[31:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf <= '0;
      pend    <= '0;
    end else begin
      bit_buf <= bit_buf_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp <= grp_next;
    end
  end

endmodule

### rtl/aacep_checker.sv
// ----------------------------------------------------------------------------
// aacep_checker
// Port-level checks for the escape-pair Huffman encoder.
// ----------------------------------------------------------------------------
module aacep_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // an item without a word is a single, empty result
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[37:0] == 38'd0))
    else $error("empty result carries bits or is not last");

  // only the final result of an item may hold a partial word
  a_full_words: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser && (m_tdata[37:32] == 6'd32))
    else $error("non-final result is not a full word");

  // a pair never adds more than 74 bits
  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[44:38] <= 7'd74))
    else $error("pair bit count out of range");

endmodule

bind aac_escape_pair_huffman_encoder_top aacep_checker u_aacep_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
